// ===== design/spsb_pkg.sv =====
// Shared types and constants of the scanline palette sprite blitter.
package spsb_pkg;

  // Line geometry; the line buffer is split into four interleaved banks.
  localparam int LINE_WIDTH = 220;
  localparam int LANES      = 4;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int BANK_DEPTH = (LINE_WIDTH + LANES - 1) / LANES;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_DRAW    = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Command broadcast from the top level to every lane.
  typedef struct packed {
    logic        draw;
    logic        pal_we;
    logic        depth;
    logic [3:0]  pal_idx;
    logic [15:0] pal_color;
    logic [7:0]  packed_byte;
    logic [6:0]  group;
    logic [15:0] sx;
    logic [3:0]  transp;
  } lane_cmd_t;

  // Registered pixel write produced by one lane.
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [15:0]      color;
  } lane_wr_t;

  // Write and read requests for one line buffer bank.
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [15:0]        data;
  } bank_wr_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } bank_rd_t;

endpackage

// ===== design/spsb_if.sv =====
// Handshake interfaces for the input item and result word channels.
interface spsb_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        pixel_depth;
  logic [3:0]  palette_index;
  logic [15:0] palette_color;
  logic [7:0]  packed_byte;
  logic [6:0]  group_index;
  logic signed [15:0] sprite_x;
  logic [15:0] screen_row;
  logic signed [15:0] sprite_top;
  logic [7:0]  sprite_height;
  logic [3:0]  transparent_index;
  logic [7:0]  read_position;

  modport source (
    output valid, mode, pixel_depth, palette_index, palette_color, packed_byte,
           group_index, sprite_x, screen_row, sprite_top, sprite_height,
           transparent_index, read_position,
    input  ready
  );
  modport sink (
    input  valid, mode, pixel_depth, palette_index, palette_color, packed_byte,
           group_index, sprite_x, screen_row, sprite_top, sprite_height,
           transparent_index, read_position,
    output ready
  );
endinterface

interface spsb_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

// ===== design/scanline_palette_sprite_blitter_core.sv =====
// Top level: input decode, four drawing lanes, bank merge and result register.
//
// The block accepts one word per clock: a palette load, a sprite byte draw or
// a pixel read. The four lanes handle the pixels of a sprite byte, one each,
// and keep their own palette copy; their writes are merged onto four
// column-interleaved line buffer banks, so all pixels of a byte land in the
// same cycle. A read is registered in the read request stage and then in the
// bank read register. Input is stalled only while a finished result waits in
// the output register and the sink is not ready. Line buffer and palette read
// as zero after reset with no clearing pass.
module scanline_palette_sprite_blitter_core (
  input  logic clk,
  input  logic rst,
  spsb_item_if.sink     item,
  spsb_result_if.source result
);
  import spsb_pkg::*;

  logic               adv;
  logic               accept;
  logic signed [17:0] row_ext;
  logic signed [17:0] top_ext;
  logic signed [17:0] bottom;
  logic               in_row;
  logic [17:0]        rpos_ext;
  lane_cmd_t          cmd;
  lane_wr_t           lane_wr [LANES];
  bank_wr_t           bank_wr [LANES];
  bank_rd_t           bank_rd [LANES];
  logic [15:0]        bank_rdata [LANES];

  logic               s1_rd;
  logic               s1_rd_ok;
  logic [1:0]         s1_rbank;
  logic [BANK_AW-1:0] s1_raddr;
  logic               out_valid;
  logic               out_ok;
  logic [1:0]         out_bank;

  // Pipeline moves whenever the result register is free or being emptied.
  assign adv        = ~out_valid | result.ready;
  assign item.ready = adv;
  assign accept     = item.valid & adv;

  // Row test in full signed arithmetic.
  always_comb begin
    row_ext = signed'({2'b00, item.screen_row});
    top_ext = 18'(item.sprite_top);
    bottom  = top_ext + signed'({10'd0, item.sprite_height});
    in_row  = (row_ext >= top_ext) && (row_ext < bottom);
  end

  // Command broadcast to the lanes.
  always_comb begin
    cmd.draw        = accept && (mode_t'(item.mode) == MODE_DRAW) && in_row;
    cmd.pal_we      = accept && (mode_t'(item.mode) == MODE_PALETTE);
    cmd.depth       = item.pixel_depth;
    cmd.pal_idx     = item.palette_index;
    cmd.pal_color   = item.palette_color;
    cmd.packed_byte = item.packed_byte;
    cmd.group       = item.group_index;
    cmd.sx          = item.sprite_x;
    cmd.transp      = item.transparent_index;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    spsb_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .lane_id (2'(l)),
      .cmd     (cmd),
      .wr      (lane_wr[l])
    );
  end

  // Merge: each bank takes the lane whose column falls in it.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_wr[b] = '0;
      for (int l = 0; l < LANES; l++) begin
        if (adv && lane_wr[l].en && (lane_wr[l].col[1:0] == 2'(b))) begin
          bank_wr[b].en   = 1'b1;
          bank_wr[b].addr = lane_wr[l].col[COL_W-1:2];
          bank_wr[b].data = lane_wr[l].color;
        end
      end
      bank_rd[b].en   = adv && s1_rd && s1_rd_ok && (s1_rbank == 2'(b));
      bank_rd[b].addr = s1_raddr;
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    spsb_bank u_bank (
      .clk   (clk),
      .rst   (rst),
      .wr    (bank_wr[b]),
      .rd    (bank_rd[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Read request stage, aligned with the lane write stage.
  assign rpos_ext = 18'(item.read_position);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_rd <= 1'b0;
    end else if (adv) begin
      s1_rd <= accept && (mode_t'(item.mode) == MODE_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rd_ok <= rpos_ext < 18'(LINE_WIDTH);
      s1_rbank <= item.read_position[1:0];
      s1_raddr <= BANK_AW'(rpos_ext >> 2);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok   <= s1_rd_ok;
      out_bank <= s1_rbank;
    end
  end

  assign result.valid       = out_valid;
  assign result.pixel_color = out_ok ? bank_rdata[out_bank] : 16'd0;

endmodule

// ===== design/spsb_lane.sv =====
// One drawing lane: its own palette copy and the column and color of one pixel.
module spsb_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [1:0]         lane_id,
  input  spsb_pkg::lane_cmd_t cmd,
  output spsb_pkg::lane_wr_t  wr
);
  import spsb_pkg::*;

  logic [15:0]        palette [16];
  logic [2:0]         shift;
  logic [7:0]         nib;
  logic [3:0]         idx;
  logic               active;
  logic signed [17:0] col;
  logic               hit;

  // Palette copy, written by every palette load.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) palette[i] <= '0;
    end else if (cmd.pal_we) begin
      palette[cmd.pal_idx] <= cmd.pal_color;
    end
  end

  // Pick this lane's index out of the byte, high bits first.
  always_comb begin
    if (cmd.depth) begin
      shift = 3'd6 - {lane_id, 1'b0};
    end else begin
      shift = lane_id[0] ? 3'd0 : 3'd4;
    end
    nib    = cmd.packed_byte >> shift;
    idx    = cmd.depth ? {2'b00, nib[1:0]} : nib[3:0];
    active = cmd.depth | ~lane_id[1];
  end

  // Screen column of this pixel and the clip and transparency test.
  always_comb begin
    col = 18'(signed'(cmd.sx))
        + (cmd.depth ? signed'({9'd0, cmd.group, 2'b00})
                     : signed'({10'd0, cmd.group, 1'b0}))
        + signed'({16'd0, lane_id});
    hit = cmd.draw && active && (idx != cmd.transp)
          && (col >= 18'sd0) && (col < 18'(LINE_WIDTH));
  end

  // Registered write toward the line buffer banks; only the enable is reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      wr.col   <= col[COL_W-1:0];
      wr.color <= palette[idx];
    end
    if (rst) begin
      wr.en <= 1'b0;
    end else if (adv) begin
      wr.en <= hit;
    end
  end

endmodule

// ===== design/spsb_bank.sv =====
// One interleaved bank of the line buffer, with per-entry written flags.
module spsb_bank (
  input  logic               clk,
  input  logic               rst,
  input  spsb_pkg::bank_wr_t wr,
  input  spsb_pkg::bank_rd_t rd,
  output logic [15:0]        rdata
);
  import spsb_pkg::*;

  logic [15:0]           mem [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] written;
  logic [15:0]           rd_q;
  logic                  rd_written_q;

  // Storage array; never-written entries read as zero.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
  end

  // Written flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr.en) written[wr.addr] <= 1'b1;
      if (rd.en) rd_written_q <= written[rd.addr];
    end
  end

  assign rdata = rd_written_q ? rd_q : 16'd0;

endmodule
